/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define SHBI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SHBI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/shbi_pkg.sv */
`default_nettype none

package shbi_pkg;

    localparam int TABLE_SIZE       = 4096;
    localparam int SLOTS_PER_BUCKET = 16;
    localparam int PARTICLE_COUNT   = 1024;

    localparam int POS_W     = 24;
    localparam int CELL_W    = POS_W + 1;
    localparam int CS_W      = 23;
    localparam int MULT_W    = 32;
    localparam int ID_W      = $clog2(PARTICLE_COUNT);
    localparam int BUCKET_W  = $clog2(TABLE_SIZE);
    localparam int SLOT_W    = $clog2(SLOTS_PER_BUCKET);
    localparam int FILL_W    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int MEMBER_AW = BUCKET_W + SLOT_W;
    localparam int MEMBER_DEPTH = TABLE_SIZE * SLOTS_PER_BUCKET;
    localparam int DIV_CNT_W = $clog2(POS_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [MULT_W-1:0] MULT_X_RESET = 32'd73856093;
    localparam logic [MULT_W-1:0] MULT_Y_RESET = 32'd19349663;
    localparam logic [CS_W-1:0]   PITCH_RESET  = 23'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_MULT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 2'd2;

    localparam logic ACT_CLEAR  = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [ID_W-1:0]         particle_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } shbi_req_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [SLOT_W-1:0]   slot;
        logic                stored;
    } shbi_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_FIX,
        ST_MUL_X,
        ST_MUL_Y,
        ST_READ,
        ST_WRITE
    } shbi_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fix;
        logic mul_x;
        logic mul_y;
        logic rd;
        logic wr;
        logic clr_step;
    } shbi_cmd_t;

    typedef struct packed {
        logic div_last;
        logic clr_last;
    } shbi_status_t;

endpackage

`default_nettype wire

/* hdl/shbi_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per step, with floor correction.
module shbi_div (
    input  wire logic                                 clk,
    input  wire logic                                 load,
    input  wire logic                                 step,
    input  wire logic                                 fix,
    input  wire logic signed [shbi_pkg::POS_W-1:0]    dividend,
    input  wire logic [shbi_pkg::CS_W-1:0]            divisor,
    output logic signed [shbi_pkg::CELL_W-1:0]        coord
);

    logic                          neg_reg;
    logic [shbi_pkg::POS_W-1:0]    quo_reg;
    logic [shbi_pkg::CS_W-1:0]     rem_reg;
    logic [shbi_pkg::CS_W-1:0]     den_reg;
    logic signed [shbi_pkg::CELL_W-1:0] coord_reg;

    logic [shbi_pkg::POS_W-1:0]    mag;
    logic [shbi_pkg::POS_W-1:0]    rem_sh;
    logic [shbi_pkg::POS_W-1:0]    diff;
    logic                          ge;
    logic [shbi_pkg::CELL_W-1:0]   quo_ext;
    logic signed [shbi_pkg::CELL_W-1:0] coord_next;

    always_comb
    begin
        mag    = dividend[shbi_pkg::POS_W-1] ? (~dividend + 1'b1) : dividend;
        rem_sh = {rem_reg, quo_reg[shbi_pkg::POS_W-1]};
        ge     = rem_sh >= {1'b0, den_reg};
        diff   = rem_sh - {1'b0, den_reg};
        quo_ext = {1'b0, quo_reg};
        // negative with remainder: -q-1 == ~q
        if (!neg_reg)
        begin
            coord_next = quo_ext;
        end
        else if (rem_reg != '0)
        begin
            coord_next = ~quo_ext;
        end
        else
        begin
            coord_next = -quo_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= dividend[shbi_pkg::POS_W-1];
            quo_reg <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= ge ? diff[shbi_pkg::CS_W-1:0] : rem_sh[shbi_pkg::CS_W-1:0];
            quo_reg <= {quo_reg[shbi_pkg::POS_W-2:0], ge};
        end
        if (fix)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

`default_nettype wire

/* hdl/shbi_ctrl.sv */
`default_nettype none

module shbi_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   action,
    input  wire shbi_pkg::shbi_status_t status,
    output shbi_pkg::shbi_cmd_t         cmd,
    output logic                        busy
);

    shbi_pkg::shbi_state_t state_reg;
    shbi_pkg::shbi_state_t state_next;

    // reset lands in the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shbi_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            shbi_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (action == shbi_pkg::ACT_INSERT)
                    begin
                        cmd.load   = 1'b1;
                        state_next = shbi_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = shbi_pkg::ST_CLEAR;
                    end
                end
            end
            shbi_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = shbi_pkg::ST_IDLE;
                end
            end
            shbi_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = shbi_pkg::ST_FIX;
                end
            end
            shbi_pkg::ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = shbi_pkg::ST_MUL_X;
            end
            shbi_pkg::ST_MUL_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = shbi_pkg::ST_MUL_Y;
            end
            shbi_pkg::ST_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = shbi_pkg::ST_READ;
            end
            shbi_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = shbi_pkg::ST_WRITE;
            end
            shbi_pkg::ST_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = shbi_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = shbi_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != shbi_pkg::ST_IDLE);

endmodule

`default_nettype wire

/* hdl/shbi_datapath.sv */
`default_nettype none

module shbi_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire shbi_pkg::shbi_req_t               req,
    input  wire shbi_pkg::shbi_cmd_t               cmd,
    output shbi_pkg::shbi_status_t                 status,
    input  wire logic                              cfg_valid,
    input  wire logic [shbi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [shbi_pkg::MULT_W-1:0]       cfg_data,
    output logic                                   res_valid,
    output shbi_pkg::shbi_res_t                    res
);

    logic [shbi_pkg::MULT_W-1:0]    mult_x_reg;
    logic [shbi_pkg::MULT_W-1:0]    mult_y_reg;
    logic [shbi_pkg::CS_W-1:0]      grid_pitch_reg;

    logic [shbi_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [shbi_pkg::BUCKET_W-1:0]  clr_cnt_reg;
    logic                           res_valid_reg;

    logic [shbi_pkg::ID_W-1:0]      id_reg;
    logic [shbi_pkg::MULT_W-1:0]    hash_reg;
    logic [shbi_pkg::FILL_W-1:0]    fill_rd_reg;
    shbi_pkg::shbi_res_t            res_reg;

    logic [shbi_pkg::FILL_W-1:0]    fill_mem [shbi_pkg::TABLE_SIZE];
    logic [shbi_pkg::ID_W-1:0]      member_mem [shbi_pkg::MEMBER_DEPTH];

    logic [shbi_pkg::CS_W-1:0]      divisor;
    logic signed [shbi_pkg::CELL_W-1:0] cx;
    logic signed [shbi_pkg::CELL_W-1:0] cy;
    logic [shbi_pkg::MULT_W-1:0]    mul_a;
    logic [shbi_pkg::MULT_W-1:0]    mul_b;
    logic [2*shbi_pkg::MULT_W-1:0]  product;
    logic [shbi_pkg::BUCKET_W-1:0]  bucket;
    logic                           has_room;
    logic                           fill_we;
    logic [shbi_pkg::BUCKET_W-1:0]  fill_waddr;
    logic [shbi_pkg::FILL_W-1:0]    fill_wdata;
    logic                           member_we;

    // pitch zero behaves as one
    assign divisor = (grid_pitch_reg == '0) ? shbi_pkg::CS_W'(1) : grid_pitch_reg;

    shbi_div u_div_x (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .fix      (cmd.fix),
        .dividend (req.pos_x),
        .divisor  (divisor),
        .coord    (cx)
    );

    shbi_div u_div_y (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .fix      (cmd.fix),
        .dividend (req.pos_y),
        .divisor  (divisor),
        .coord    (cy)
    );

    // one shared 32x32 multiplier, x then y; only the low word is kept
    always_comb
    begin
        if (cmd.mul_y)
        begin
            mul_a = {{(shbi_pkg::MULT_W-shbi_pkg::CELL_W){cy[shbi_pkg::CELL_W-1]}}, cy};
            mul_b = mult_y_reg;
        end
        else
        begin
            mul_a = {{(shbi_pkg::MULT_W-shbi_pkg::CELL_W){cx[shbi_pkg::CELL_W-1]}}, cx};
            mul_b = mult_x_reg;
        end
        product = mul_a * mul_b;
    end

    // floored mod of a power-of-two table size is the low bits
    assign bucket   = hash_reg[shbi_pkg::BUCKET_W-1:0];
    assign has_room = fill_rd_reg < shbi_pkg::FILL_W'(shbi_pkg::SLOTS_PER_BUCKET);

    always_comb
    begin
        if (cmd.clr_step)
        begin
            fill_we    = 1'b1;
            fill_waddr = clr_cnt_reg;
            fill_wdata = '0;
        end
        else
        begin
            fill_we    = cmd.wr && has_room;
            fill_waddr = bucket;
            fill_wdata = fill_rd_reg + 1'b1;
        end
        member_we = cmd.wr && has_room;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_x_reg     <= shbi_pkg::MULT_X_RESET;
            mult_y_reg     <= shbi_pkg::MULT_Y_RESET;
            grid_pitch_reg <= shbi_pkg::PITCH_RESET;
            div_cnt_reg    <= '0;
            clr_cnt_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    shbi_pkg::CFG_MULT_X: mult_x_reg     <= cfg_data;
                    shbi_pkg::CFG_MULT_Y: mult_y_reg     <= cfg_data;
                    shbi_pkg::CFG_PITCH:  grid_pitch_reg <= cfg_data[shbi_pkg::CS_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= status.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            res_valid_reg <= cmd.wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg <= req.particle_id;
        end
        if (cmd.mul_x)
        begin
            hash_reg <= product[shbi_pkg::MULT_W-1:0];
        end
        else if (cmd.mul_y)
        begin
            hash_reg <= hash_reg ^ product[shbi_pkg::MULT_W-1:0];
        end
        if (cmd.wr)
        begin
            res_reg.bucket <= bucket;
            res_reg.stored <= has_room;
            res_reg.slot   <= has_room ? fill_rd_reg[shbi_pkg::SLOT_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (cmd.rd)
        begin
            fill_rd_reg <= fill_mem[bucket];
        end
    end

    always_ff @(posedge clk)
    begin
        if (member_we)
        begin
            member_mem[{bucket, fill_rd_reg[shbi_pkg::SLOT_W-1:0]}] <= id_reg;
        end
    end

    assign status.div_last = (div_cnt_reg == shbi_pkg::DIV_CNT_W'(shbi_pkg::POS_W - 1));
    assign status.clr_last = (clr_cnt_reg == shbi_pkg::BUCKET_W'(shbi_pkg::TABLE_SIZE - 1));
    assign res_valid       = res_valid_reg;
    assign res             = res_reg;

endmodule

`default_nettype wire

/* hdl/spatial_hash_bucket_insert_unit.sv */
// Spatial hash bucket insert unit.
// Request channel: start with req (action, particle_id, pos_x, pos_y); a request
// is taken at a clock edge where start is high and busy is low.
// An insert request divides both coordinates by the grid pitch (floored), hashes
// the cell with the two multipliers, and appends the id to its bucket when
// the bucket has room. One result per insert appears on res for exactly one
// cycle with res_valid high; the receiver cannot stall it.
// An insert passes through the two 24-step bit-serial dividers, then the floor
// fix, one shared 32x32 multiplier used twice, one read/write of the bucket
// fill memory and the result register; busy stays high until the bucket
// write, so no new request is taken while an insert is in flight.
// A clear request gives no result and holds busy while the fill counts are
// swept to zero one bucket per cycle.
// After reset the same clearing pass runs; busy stays high until it ends.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken
// only while busy is low, so no request in flight sees a change.
`default_nettype none

module spatial_hash_bucket_insert_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire shbi_pkg::shbi_req_t               req,
    output logic                                   res_valid,
    output shbi_pkg::shbi_res_t                    res,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [shbi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [shbi_pkg::MULT_W-1:0]       cfg_data
);

    shbi_pkg::shbi_cmd_t    cmd;
    shbi_pkg::shbi_status_t status;

    assign cfg_ready = !busy;

    shbi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (req.action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    shbi_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

`default_nettype wire

/* hdl/shbi_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module shbi_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 res_valid,
    input wire shbi_pkg::shbi_res_t  res
);

    `SHBI_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted request did not raise busy")
    `SHBI_ASSERT(a_res_single, clk, rst_n, res_valid |=> !res_valid, "result strobe longer than one cycle")
    `SHBI_ASSERT(a_res_after_busy, clk, rst_n, res_valid |-> $past(busy), "result without a request in flight")
    `SHBI_ASSERT(a_drop_slot, clk, rst_n, (res_valid && !res.stored) |-> (res.slot == '0), "dropped id reports a nonzero slot")

endmodule

bind spatial_hash_bucket_insert_unit shbi_checker u_shbi_checker (.*);

`default_nettype wire

/* tb/sv/tb_spatial_hash_bucket_insert_unit.sv */
module tb_spatial_hash_bucket_insert_unit;
    import shbi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int INSERT_LAT  = 30;
    localparam int CYCLE_LIMIT = 1500000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    shbi_req_t            req       = '0;
    logic                 res_valid;
    shbi_res_t            res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MULT_W-1:0]    cfg_data  = '0;

    spatial_hash_bucket_insert_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the registers and the bucket fill counts
    logic [MULT_W-1:0] mult_x_q     = MULT_X_RESET;
    logic [MULT_W-1:0] mult_y_q     = MULT_Y_RESET;
    logic [CS_W-1:0]   grid_pitch_q = PITCH_RESET;
    logic [FILL_W-1:0] fill_count [TABLE_SIZE];

    shbi_req_t pending_reqs [$];
    shbi_res_t expected_res [$];

    logic   req_taken   = 1'b0;
    int     gap_left    = 0;
    int     calm_left   = 0;
    int     errors      = 0;
    int     n_checked   = 0;
    int     n_dropped   = 0;
    int     n_clears    = 0;
    int     n_cfg       = 0;
    longint cycle_count = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        foreach (fill_count[i])
            fill_count[i] = '0;
    end

    // floored division by the pitch, zero pitch counts as one
    function automatic longint cell_of(logic signed [POS_W-1:0] pos);
        longint p;
        longint cs;
        longint q;
        p  = longint'(pos);
        cs = (grid_pitch_q == '0) ? 64'sd1 : longint'(grid_pitch_q);
        q  = p / cs;
        if (p % cs != 0 && p < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic shbi_res_t insert_into_table(shbi_req_t r);
        shbi_res_t   o;
        longint      qx;
        longint      qy;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] h;
        qx = cell_of(r.pos_x);
        qy = cell_of(r.pos_y);
        cx = qx[31:0];
        cy = qy[31:0];
        h  = (cx * mult_x_q) ^ (cy * mult_y_q);
        // floored mod by a power-of-two table size keeps the low bits
        o.bucket = h[BUCKET_W-1:0];
        if (fill_count[o.bucket] < SLOTS_PER_BUCKET)
        begin
            o.slot   = fill_count[o.bucket][SLOT_W-1:0];
            o.stored = 1'b1;
            fill_count[o.bucket] = fill_count[o.bucket] + 1'b1;
        end
        else
        begin
            o.slot   = '0;
            o.stored = 1'b0;
        end
        return o;
    endfunction

    // mostly short gaps, a few long, with calm stretches of back-to-back requests
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(49) == 0)
            calm_left = $urandom_range(10, 40);
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 96)
            return $urandom_range(5, 35);
        return $urandom_range(36, 120);
    endfunction

    always @(posedge clk)
    begin
        shbi_res_t want;
        if (rst_n)
        begin
            if (res_valid)
            begin
                if (expected_res.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected result: expected none, got %0d/%0d/%0d",
                             $time, res.bucket, res.slot, res.stored);
                end
                else
                begin
                    want = expected_res.pop_front();
                    n_checked = n_checked + 1;
                    if (!want.stored)
                        n_dropped = n_dropped + 1;
                    if (res.bucket !== want.bucket)
                    begin
                        errors = errors + 1;
                        $display("%0t: bucket mismatch: expected %0d, got %0d",
                                 $time, want.bucket, res.bucket);
                    end
                    if (res.slot !== want.slot)
                    begin
                        errors = errors + 1;
                        $display("%0t: slot mismatch: expected %0d, got %0d",
                                 $time, want.slot, res.slot);
                    end
                    if (res.stored !== want.stored)
                    begin
                        errors = errors + 1;
                        $display("%0t: stored mismatch: expected %0d, got %0d",
                                 $time, want.stored, res.stored);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                n_cfg = n_cfg + 1;
                case (cfg_index)
                    CFG_MULT_X: mult_x_q     = cfg_data;
                    CFG_MULT_Y: mult_y_q     = cfg_data;
                    CFG_PITCH:  grid_pitch_q = cfg_data[CS_W-1:0];
                    default:    ;
                endcase
            end
            if (start && !busy)
            begin
                if (req.action == ACT_INSERT)
                    expected_res.push_back(insert_into_table(req));
                else
                begin
                    foreach (fill_count[i])
                        fill_count[i] = '0;
                    n_clears = n_clears + 1;
                end
            end
            req_taken <= start && !busy;
        end
    end

    // request driver: hold start until taken, then idle for the chosen gap
    always @(negedge clk)
    begin
        if (rst_n && !(start && !req_taken))
        begin
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                req      <= pending_reqs.pop_front();
                start    <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, expected_res.size());
            $display("tb_spatial_hash_bucket_insert_unit: done, errors");
            $finish;
        end
    end

    function automatic shbi_req_t insert_req(logic [ID_W-1:0] id, logic [POS_W-1:0] x,
                                             logic [POS_W-1:0] y);
        shbi_req_t r;
        r.action      = ACT_INSERT;
        r.particle_id = id;
        r.pos_x       = x;
        r.pos_y       = y;
        return r;
    endfunction

    function automatic shbi_req_t clear_req();
        shbi_req_t r;
        r        = '0;
        r.action = ACT_CLEAR;
        r.particle_id = ID_W'($urandom);
        return r;
    endfunction

    function automatic logic [POS_W-1:0] rand_coord();
        if ($urandom_range(3) == 0)
            return POS_W'($urandom_range(0, 4095) - 2048);
        return POS_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] edge_coord();
        case ($urandom_range(4))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return 24'h000001;
        endcase
    endfunction

    // clusters on one position fill buckets up; scatter, edge values and occasional clears mixed in
    task automatic add_random(int n);
        int                done;
        int                r;
        int                len;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                x   = rand_coord();
                y   = rand_coord();
                len = $urandom_range(8, 24);
                repeat (len)
                    pending_reqs.push_back(insert_req(ID_W'($urandom), x, y));
                done = done + len;
            end
            else if (r < 85)
            begin
                len = $urandom_range(4, 12);
                repeat (len)
                    pending_reqs.push_back(insert_req(ID_W'($urandom), rand_coord(),
                                                      rand_coord()));
                done = done + len;
            end
            else if (r < 95)
            begin
                len = $urandom_range(2, 5);
                repeat (len)
                    pending_reqs.push_back(insert_req(ID_W'($urandom), edge_coord(),
                                                      edge_coord()));
                done = done + len;
            end
            else
            begin
                pending_reqs.push_back(clear_req());
                done = done + 1;
            end
        end
    endtask

    // block idle: all requests taken, all results in, clear sweep finished
    task automatic drain();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || start || expected_res.size() != 0);
        repeat (INSERT_LAT + 10) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [MULT_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: corners, floor on negatives, exact division, ids at both ends
        pending_reqs.push_back(insert_req(10'd0, 24'h7FFFFF, 24'h7FFFFF));
        pending_reqs.push_back(insert_req(10'd1023, 24'h800000, 24'h800000));
        pending_reqs.push_back(insert_req(ID_W'($urandom), 24'h000000, 24'h000000));
        pending_reqs.push_back(insert_req(ID_W'($urandom), 24'hFFFFFF, 24'hFFFFFF));
        pending_reqs.push_back(insert_req(ID_W'($urandom), 24'd512, -24'sd512));
        pending_reqs.push_back(insert_req(ID_W'($urandom), 24'h800000, 24'h7FFFFF));
        // one bucket past full, then a clear and the bucket starts over
        repeat (17)
            pending_reqs.push_back(insert_req(ID_W'($urandom), 24'd1000, -24'sd3000));
        pending_reqs.push_back(clear_req());
        pending_reqs.push_back(insert_req(ID_W'($urandom), 24'd1000, -24'sd3000));
        add_random(300);

        for (int ph = 1; ph <= 5; ph++)
        begin
            drain();
            case (ph)
                1:
                begin
                    cfg_write(CFG_MULT_X, 32'h0000_0000);
                    cfg_write(CFG_MULT_Y, 32'hFFFF_FFFF);
                    cfg_write(CFG_PITCH, 32'd1);
                end
                2:
                begin
                    cfg_write(CFG_MULT_X, $urandom);
                    cfg_write(CFG_MULT_Y, $urandom);
                    // upper bits beyond the register width are dropped
                    cfg_write(CFG_PITCH, 32'hFF7F_FFFF);
                end
                3:
                begin
                    cfg_write(CFG_MULT_X, 32'hFFFF_FFFF);
                    cfg_write(CFG_MULT_Y, 32'h0000_0000);
                    cfg_write(CFG_PITCH, 32'd0);
                    cfg_write(CFG_UNUSED, $urandom);
                end
                4:
                begin
                    cfg_write(CFG_MULT_X, 32'd1);
                    cfg_write(CFG_MULT_Y, 32'd1);
                    cfg_write(CFG_PITCH, 32'd256);
                end
                default:
                begin
                    cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
                    cfg_write(CFG_MULT_X, $urandom);
                    cfg_write(CFG_MULT_Y, $urandom);
                    cfg_write(CFG_PITCH, $urandom_range(1, 4096));
                end
            endcase
            add_random(225);
        end
        drain();

        $display("checked %0d insert results, %0d of them dropped on a full bucket; %0d clears",
                 n_checked, n_dropped, n_clears);
        $display("%0d register writes over six settings, grid pitch from zero to full scale",
                 n_cfg);
        if (errors == 0 && expected_res.size() == 0)
            $display("tb_spatial_hash_bucket_insert_unit: done, clean");
        else
            $display("tb_spatial_hash_bucket_insert_unit: done, errors");
        $finish;
    end

endmodule
